[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Simulation builds get the checks;
// synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define BSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bsm_pkg.sv]
`timescale 1ns / 1ps
package bsm_pkg;

  // Coordinates are signed Q12.12; the binary point cancels in every step.
  localparam int COORD_WIDTH = 24;
  localparam int RAD_W  = COORD_WIDTH - 1;
  localparam int MRAD_W = COORD_WIDTH + 1;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int GROW_W = 2 * COORD_WIDTH + 2;
  localparam int ROOT_W = DIFF_W;
  localparam int SREM_W = ROOT_W + 3;
  localparam int QUO_W  = DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [RAD_W-1:0]  rad_t;
  typedef logic [MRAD_W-1:0] mrad_t;
  typedef logic [DIFF_W-1:0] mag_t;
  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [GROW_W-1:0] grow_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    rad_t   first_radius;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
    rad_t   second_radius;
  } in_beat_t;

  typedef struct packed {
    coord_t merged_x;
    coord_t merged_y;
    coord_t merged_z;
    mrad_t  merged_radius;
    grow_t  growth;
    logic   overlapping;
  } out_beat_t;

  // Side data carried alongside the square root.
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] c1;
    logic [2:0][COORD_WIDTH-1:0] c2;
    logic [2:0]                  neg;
    logic [2:0][DIFF_W-1:0]      absd;
    rad_t                        r1;
    rad_t                        r2;
    logic                        contain;
    logic                        over;
  } sq_ctx_t;

  // Side data carried alongside the dividers.
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] c1;
    logic [2:0][COORD_WIDTH-1:0] c2;
    logic [2:0]                  neg;
    logic                        contain;
    logic                        use_c1;
    mrad_t                       radius;
    grow_t                       grow;
    logic                        over;
  } dv_ctx_t;

endpackage

[rtl/bsm_in_if.sv]
`timescale 1ns / 1ps
interface bsm_in_if;
  import bsm_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bsm_out_if.sv]
`timescale 1ns / 1ps
interface bsm_out_if;
  import bsm_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bsm_sqrt_pipe.sv]
`timescale 1ns / 1ps
// Integer square root, one result bit per register stage.
module bsm_sqrt_pipe import bsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  sq_t     in_rad,
  input  sq_ctx_t in_ctx,
  output logic    out_valid,
  output root_t   out_root,
  output sq_ctx_t out_ctx
);

  localparam int STEPS = ROOT_W;

  logic [STEPS-1:0]  v_r;
  sq_t               rad_r   [STEPS];
  logic [SREM_W-1:0] rem_r   [STEPS];
  root_t             root_r  [STEPS];
  sq_ctx_t           ctx_r   [STEPS];

  logic [STEPS-1:0]  p_v;
  sq_t               p_rad   [STEPS];
  logic [SREM_W-1:0] p_rem   [STEPS];
  root_t             p_root  [STEPS];
  sq_ctx_t           p_ctx   [STEPS];

  logic [SREM_W-1:0] sh_c    [STEPS];
  logic [SREM_W-1:0] trial_c [STEPS];
  sq_t               rad_nxt [STEPS];
  logic [SREM_W-1:0] rem_nxt [STEPS];
  root_t             root_nxt[STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign p_v[k]    = in_valid;
      assign p_rad[k]  = in_rad;
      assign p_rem[k]  = '0;
      assign p_root[k] = '0;
      assign p_ctx[k]  = in_ctx;
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_rad[k]  = rad_r[k-1];
      assign p_rem[k]  = rem_r[k-1];
      assign p_root[k] = root_r[k-1];
      assign p_ctx[k]  = ctx_r[k-1];
    end

    assign sh_c[k]    = {p_rem[k][SREM_W-3:0], p_rad[k][SQ_W-1 -: 2]};
    assign trial_c[k] = {1'b0, p_root[k], 2'b01};
    assign rad_nxt[k] = {p_rad[k][SQ_W-3:0], 2'b00};

    always_comb begin
      if (sh_c[k] >= trial_c[k]) begin
        rem_nxt[k]  = sh_c[k] - trial_c[k];
        root_nxt[k] = {p_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = sh_c[k];
        root_nxt[k] = {p_root[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        ctx_r[k]  <= p_ctx[k];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_ctx   = ctx_r[STEPS-1];

endmodule

[rtl/bsm_div_pipe.sv]
`timescale 1ns / 1ps
// Three restoring dividers side by side, one quotient bit per register stage.
// The quotient is known to fit QUO_W bits, so the upper dividend half starts
// as the partial remainder.
module bsm_div_pipe import bsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][SQ_W-1:0] in_prod,
  input  root_t                in_dist,
  input  dv_ctx_t              in_ctx,
  output logic                 out_valid,
  output logic [2:0][QUO_W-1:0] out_quo,
  output dv_ctx_t              out_ctx
);

  localparam int STEPS = QUO_W;

  logic [STEPS-1:0]          v_r;
  logic [2:0][ROOT_W-1:0]    rem_r  [STEPS];
  logic [2:0][QUO_W-1:0]     lq_r   [STEPS];
  root_t                     dist_r [STEPS];
  dv_ctx_t                   ctx_r  [STEPS];

  logic [STEPS-1:0]          p_v;
  logic [2:0][ROOT_W-1:0]    p_rem  [STEPS];
  logic [2:0][QUO_W-1:0]     p_lq   [STEPS];
  root_t                     p_dist [STEPS];
  dv_ctx_t                   p_ctx  [STEPS];

  logic [2:0][ROOT_W:0]      t_c    [STEPS];
  logic [2:0][ROOT_W:0]      dif_c  [STEPS];
  logic [2:0][ROOT_W-1:0]    rem_nxt[STEPS];
  logic [2:0][QUO_W-1:0]     lq_nxt [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign p_v[k]    = in_valid;
      assign p_dist[k] = in_dist;
      assign p_ctx[k]  = in_ctx;
      for (genvar j = 0; j < 3; j++) begin : g_load
        assign p_rem[k][j] = in_prod[j][SQ_W-1:QUO_W];
        assign p_lq[k][j]  = in_prod[j][QUO_W-1:0];
      end
    end else begin : g_next
      assign p_v[k]    = v_r[k-1];
      assign p_dist[k] = dist_r[k-1];
      assign p_ctx[k]  = ctx_r[k-1];
      assign p_rem[k]  = rem_r[k-1];
      assign p_lq[k]   = lq_r[k-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      assign t_c[k][j]   = {p_rem[k][j], p_lq[k][j][QUO_W-1]};
      assign dif_c[k][j] = t_c[k][j] - {1'b0, p_dist[k]};
      always_comb begin
        if (t_c[k][j] >= {1'b0, p_dist[k]}) begin
          rem_nxt[k][j] = dif_c[k][j][ROOT_W-1:0];
          lq_nxt[k][j]  = {p_lq[k][j][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][j] = t_c[k][j][ROOT_W-1:0];
          lq_nxt[k][j]  = {p_lq[k][j][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= p_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        lq_r[k]   <= lq_nxt[k];
        dist_r[k] <= p_dist[k];
        ctx_r[k]  <= p_ctx[k];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_quo   = lq_r[STEPS-1];
  assign out_ctx   = ctx_r[STEPS-1];

endmodule

[rtl/bounding_sphere_merge.sv]
`timescale 1ns / 1ps
// Merges two spheres, each a signed Q12.12 centre and an unsigned Q11.12
// radius, into their smallest enclosing sphere, and reports the growth of the
// first radius squared and whether the pair strictly overlaps. The block takes
// one beat per clock cycle while the output is not held back, and returns one
// beat for every beat taken, in order. From an accepted input beat to the
// output, registered stages form the displacement, its squares and their sum,
// the bit-per-stage square root runs, registered stages form the radius, the
// offsets and the growth, the bit-per-stage dividers run, and the result then
// sits in the output register. Whenever the result beat is held back the whole
// pipeline stalls in place, so in_ch.ready follows the output side within the
// same cycle.
`include "assert_macros.svh"
module bounding_sphere_merge import bsm_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  bsm_in_if.sink         in_ch,
  bsm_out_if.source      out_ch
);

  // The pipeline advances whenever the output register is free or drained.
  logic      en;
  logic      out_valid_r;
  out_beat_t out_data_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: displacement, its magnitude and sign, radius sum and difference.
  logic [2:0][COORD_WIDTH-1:0] c1_c, c2_c;
  logic [2:0][DIFF_W-1:0]      d_c;
  sq_ctx_t                     s1_ctx_nxt;
  rad_t                        rdiff_nxt;
  logic [RAD_W:0]              rsum_nxt;

  logic        s1_v_r;
  sq_ctx_t     s1_ctx_r;
  rad_t        s1_rdiff_r;
  logic [RAD_W:0] s1_rsum_r;

  assign c1_c[0] = in_ch.data.first_x;
  assign c1_c[1] = in_ch.data.first_y;
  assign c1_c[2] = in_ch.data.first_z;
  assign c2_c[0] = in_ch.data.second_x;
  assign c2_c[1] = in_ch.data.second_y;
  assign c2_c[2] = in_ch.data.second_z;

  always_comb begin
    s1_ctx_nxt    = '0;
    s1_ctx_nxt.c1 = c1_c;
    s1_ctx_nxt.c2 = c2_c;
    s1_ctx_nxt.r1 = in_ch.data.first_radius;
    s1_ctx_nxt.r2 = in_ch.data.second_radius;
    for (int j = 0; j < 3; j++) begin
      d_c[j] = {c2_c[j][COORD_WIDTH-1], c2_c[j]} - {c1_c[j][COORD_WIDTH-1], c1_c[j]};
      s1_ctx_nxt.neg[j]  = d_c[j][DIFF_W-1];
      s1_ctx_nxt.absd[j] = d_c[j][DIFF_W-1] ? (~d_c[j] + 1'b1) : d_c[j];
    end
    if (in_ch.data.second_radius >= in_ch.data.first_radius) begin
      rdiff_nxt = in_ch.data.second_radius - in_ch.data.first_radius;
    end else begin
      rdiff_nxt = in_ch.data.first_radius - in_ch.data.second_radius;
    end
    rsum_nxt = {1'b0, in_ch.data.first_radius} + {1'b0, in_ch.data.second_radius};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx_r   <= s1_ctx_nxt;
      s1_rdiff_r <= rdiff_nxt;
      s1_rsum_r  <= rsum_nxt;
    end
  end

  // Stage 2: one squaring multiplier per axis plus the two radius squares.
  logic             s2_v_r;
  logic [2:0][SQ_W-1:0] s2_sq_r;
  sq_t              s2_rdsq_r;
  sq_t              s2_rs2_r;
  sq_ctx_t          s2_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s2_sq_r[j] <= SQ_W'(s1_ctx_r.absd[j]) * SQ_W'(s1_ctx_r.absd[j]);
      end
      s2_rdsq_r <= SQ_W'(s1_rdiff_r) * SQ_W'(s1_rdiff_r);
      s2_rs2_r  <= SQ_W'(s1_rsum_r) * SQ_W'(s1_rsum_r);
      s2_ctx_r  <= s1_ctx_r;
    end
  end

  // Stage 3: squared centre distance. It cannot exceed three times 2^48.
  logic    s3_v_r;
  sq_t     s3_dsq_r;
  sq_t     s3_rdsq_r;
  sq_t     s3_rs2_r;
  sq_ctx_t s3_ctx_r;
  sq_ctx_t sq_in_ctx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dsq_r  <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
      s3_rdsq_r <= s2_rdsq_r;
      s3_rs2_r  <= s2_rs2_r;
      s3_ctx_r  <= s2_ctx_r;
    end
  end

  // Containment and overlap are decided as the distance enters the root.
  always_comb begin
    sq_in_ctx         = s3_ctx_r;
    sq_in_ctx.contain = s3_rdsq_r >= s3_dsq_r;
    sq_in_ctx.over    = s3_dsq_r < s3_rs2_r;
  end

  logic    sq_out_valid;
  root_t   sq_out_root;
  sq_ctx_t sq_out_ctx;

  bsm_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_rad    (s3_dsq_r),
    .in_ctx    (sq_in_ctx),
    .out_valid (sq_out_valid),
    .out_root  (sq_out_root),
    .out_ctx   (sq_out_ctx)
  );

  // Stage 4: merged radius. A contained pair keeps the larger sphere, the
  // second one on a tie; otherwise the radius is half of dist + r1 + r2.
  logic [ROOT_W:0] rsum3_c;
  mrad_t           mrad_nxt;
  logic            s4_v_r;
  mrad_t           s4_mrad_r;
  root_t           s4_dist_r;
  sq_ctx_t         s4_ctx_r;

  always_comb begin
    rsum3_c = {1'b0, sq_out_root} + (ROOT_W+1)'(sq_out_ctx.r1) + (ROOT_W+1)'(sq_out_ctx.r2);
    if (!sq_out_ctx.contain) begin
      mrad_nxt = rsum3_c[ROOT_W:1];
    end else if (sq_out_ctx.r1 > sq_out_ctx.r2) begin
      mrad_nxt = MRAD_W'(sq_out_ctx.r1);
    end else begin
      mrad_nxt = MRAD_W'(sq_out_ctx.r2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mrad_r <= mrad_nxt;
      s4_dist_r <= sq_out_root;
      s4_ctx_r  <= sq_out_ctx;
    end
  end

  // Stage 5: how far the first centre moves, and both radius squares.
  mrad_t   move_nxt;
  logic    s5_v_r;
  mrad_t   s5_move_r;
  mrad_t   s5_mrad_r;
  sq_t     s5_rr_r;
  sq_t     s5_r1sq_r;
  root_t   s5_dist_r;
  sq_ctx_t s5_ctx_r;

  always_comb begin
    if (s4_mrad_r >= MRAD_W'(s4_ctx_r.r1)) begin
      move_nxt = s4_mrad_r - MRAD_W'(s4_ctx_r.r1);
    end else begin
      move_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_move_r <= move_nxt;
      s5_mrad_r <= s4_mrad_r;
      s5_rr_r   <= SQ_W'(s4_mrad_r) * SQ_W'(s4_mrad_r);
      s5_r1sq_r <= SQ_W'(s4_ctx_r.r1) * SQ_W'(s4_ctx_r.r1);
      s5_dist_r <= s4_dist_r;
      s5_ctx_r  <= s4_ctx_r;
    end
  end

  // Stage 6: dividend per axis (|d| times move), growth and the side data
  // that the final select needs.
  dv_ctx_t              dv_in_ctx;
  logic                 s6_v_r;
  logic [2:0][SQ_W-1:0] s6_prod_r;
  root_t                s6_dist_r;
  dv_ctx_t              s6_ctx_r;

  always_comb begin
    dv_in_ctx         = '0;
    dv_in_ctx.c1      = s5_ctx_r.c1;
    dv_in_ctx.c2      = s5_ctx_r.c2;
    dv_in_ctx.neg     = s5_ctx_r.neg;
    dv_in_ctx.contain = s5_ctx_r.contain;
    dv_in_ctx.use_c1  = s5_ctx_r.contain && (s5_ctx_r.r1 > s5_ctx_r.r2);
    dv_in_ctx.radius  = s5_mrad_r;
    dv_in_ctx.over    = s5_ctx_r.over;
    if (s5_rr_r >= s5_r1sq_r) begin
      dv_in_ctx.grow = GROW_W'(s5_rr_r - s5_r1sq_r);
    end else begin
      dv_in_ctx.grow = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s6_prod_r[j] <= SQ_W'(s5_ctx_r.absd[j]) * SQ_W'(s5_move_r);
      end
      s6_dist_r <= s5_dist_r;
      s6_ctx_r  <= dv_in_ctx;
    end
  end

  logic                  dv_out_valid;
  logic [2:0][QUO_W-1:0] dv_out_quo;
  dv_ctx_t               dv_out_ctx;

  // A pair that is not contained always has a nonzero distance, so the
  // divisor is never zero where the quotient is used.
  bsm_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_v_r),
    .in_prod   (s6_prod_r),
    .in_dist   (s6_dist_r),
    .in_ctx    (s6_ctx_r),
    .out_valid (dv_out_valid),
    .out_quo   (dv_out_quo),
    .out_ctx   (dv_out_ctx)
  );

  // Final stage: move the first centre by the signed offsets, or pick the
  // containing sphere's centre, into the output register.
  logic [2:0][DIFF_W-1:0]      mc_c;
  logic [2:0][COORD_WIDTH-1:0] centre_c;
  out_beat_t                   out_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_out_ctx.neg[j]) begin
        mc_c[j] = {dv_out_ctx.c1[j][COORD_WIDTH-1], dv_out_ctx.c1[j]} - dv_out_quo[j];
      end else begin
        mc_c[j] = {dv_out_ctx.c1[j][COORD_WIDTH-1], dv_out_ctx.c1[j]} + dv_out_quo[j];
      end
      if (!dv_out_ctx.contain) begin
        centre_c[j] = mc_c[j][COORD_WIDTH-1:0];
      end else if (dv_out_ctx.use_c1) begin
        centre_c[j] = dv_out_ctx.c1[j];
      end else begin
        centre_c[j] = dv_out_ctx.c2[j];
      end
    end
    out_nxt.merged_x      = centre_c[0];
    out_nxt.merged_y      = centre_c[1];
    out_nxt.merged_z      = centre_c[2];
    out_nxt.merged_radius = dv_out_ctx.radius;
    out_nxt.growth        = dv_out_ctx.grow;
    out_nxt.overlapping   = dv_out_ctx.over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A pair that is not contained must have a nonzero distance.
  `BSM_ASSERT_IMPL(a_root_nonzero, clk, rst_n, sq_out_valid && !sq_out_ctx.contain, sq_out_root != '0)
  // When the first sphere already holds the second, the radius does not grow.
  `BSM_ASSERT_IMPL(a_grow_zero, clk, rst_n, dv_out_valid && dv_out_ctx.use_c1, dv_out_ctx.grow == '0)
  // A finished item moving on is never dropped on the way to the output.
  `BSM_ASSERT_NEXT(a_div_to_out, clk, rst_n, dv_out_valid && en, out_valid_r)

endmodule
